>>> src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/brsf_pkg.sv
package brsf_pkg;

    localparam int CACHE_DEPTH  = 16;   // power of two, slot pointers wrap naturally
    localparam int MAX_SEGMENTS = 64;
    localparam int SLOT_W       = $clog2(CACHE_DEPTH);
    localparam int OCC_W        = $clog2(CACHE_DEPTH + 1);
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);

    localparam int POS_W  = 48;
    localparam int CNT_W  = 32;
    localparam int BS_W   = 17;
    localparam int OFF_W  = 16;
    localparam int CE_W   = 5;

    localparam int IN_W   = 80;
    localparam int OUT_W  = 216;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_SEEK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [1:0] REG_BLK_BYTES  = 2'd0;
    localparam logic [1:0] REG_CACHE_ENT  = 2'd1;
    localparam logic [1:0] REG_STREAM_LEN = 2'd2;

    localparam logic [BS_W-1:0] BS_MAX = BS_W'(65536);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV,
        ST_DIVDONE,
        ST_LEN,
        ST_SISSUE,
        ST_SCMP,
        ST_MISS,
        ST_EISSUE,
        ST_ERD,
        ST_CHK,
        ST_UPD,
        ST_EMIT,
        ST_NEXT
    } t_state;

endpackage

>>> src/block_range_splitter_fifo_cache.sv
// Block range splitter with a FIFO block directory. Each transfer on the slave stream is one
// request, its opcode in tuser: read (0), absolute seek (1), directory flush (2); opcode 3
// does nothing. A read is clamped to the bytes left before stream_length, then cut at the
// current position into per-block segments, one master transfer each; the final one has
// tlast. Every segment is looked up in a 16-entry FIFO directory (hits do not reorder, a miss
// inserts and evicts the oldest entry once the configured size is reached). A miss on a
// block running past the stream end reports error and ends the request with the position
// unchanged. A read stops after 64 segments. Seek, flush and opcode 3 give one result.
// Seek, flush and opcode 3 hold the slave side for accept and emit. A read takes the accept,
// a clamp step, the bit-serial divider (position / block size, one quotient bit per cycle)
// and a step to load quotient and remainder; an empty read then goes on to the emit. Each
// segment probes directory entries (issue, compare); a hit updates and emits, a miss reads
// out the oldest entry on an eviction, checks the stream end, then inserts or reports error.
// A next step lies between segments. The directory is one small memory with a registered
// read port, probed one slot at a time. The emit cycle waits while the output register still
// holds an untaken result. The slave side is not ready while a request is in work.
module block_range_splitter_fifo_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request stream, tdata: target_position[47:0], count[79:48]
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [brsf_pkg::IN_W-1:0]   s_axis_tdata,
    // request stream, tuser: opcode[1:0]
    input  logic [1:0]                  s_axis_tuser,
    // result stream, tdata: block_index[47:0], offset_in_block[63:48], seg_length[80:64],
    // dest_offset[112:81], hit[113], slot[117:114], evicted[118], evicted_block[166:119],
    // error[167], new_position[215:168]; tlast carries last
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [brsf_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,
    // register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [brsf_pkg::POS_W-1:0]  i_cfg_data
);

    localparam int PW = brsf_pkg::POS_W;
    localparam int CW = brsf_pkg::CNT_W;
    localparam int BW = brsf_pkg::BS_W;
    localparam int OW = brsf_pkg::OFF_W;
    localparam int SW = brsf_pkg::SLOT_W;
    localparam int QW = brsf_pkg::OCC_W;
    localparam int NW = brsf_pkg::SEG_W;
    localparam int EW = brsf_pkg::CE_W;

    brsf_pkg::t_state r_state, n_state;

    // configuration registers
    logic [BW-1:0] r_bs_cfg;
    logic [EW-1:0] r_ce_cfg;
    logic [PW-1:0] r_sl;

    // architectural state
    logic [PW-1:0] r_cur;
    logic [SW-1:0] r_head;
    logic [QW-1:0] r_occ;
    logic [PW-1:0] r_ring [brsf_pkg::CACHE_DEPTH];
    logic [PW-1:0] r_rdata;

    // request working registers
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rem;
    logic [PW-1:0] r_dvd;       // dividend, shifts into quotient
    logic [BW-1:0] r_rmd;       // partial remainder
    logic [5:0]    r_dcnt;
    logic [PW-1:0] r_base;      // byte address of the block start
    logic [QW-1:0] r_k;
    logic [SW-1:0] r_probe;
    logic [NW-1:0] r_nseg;

    // current result fields
    logic [PW-1:0] r_blk;
    logic [OW-1:0] r_off;
    logic [BW-1:0] r_len;
    logic [CW-1:0] r_dst;
    logic          r_hit;
    logic [SW-1:0] r_slot;
    logic          r_ev;
    logic [PW-1:0] r_evb;
    logic          r_err;
    logic [PW-1:0] r_npos;
    logic          r_fin;

    // output register
    logic                       r_ov;
    logic [brsf_pkg::OUT_W-1:0] r_odata;
    logic                       r_olast;

    // control outputs of the sequencer
    logic          w_in_go;
    logic          w_emit_go;
    logic          w_mem_we;
    logic [SW-1:0] w_raddr;

    // effective settings and decisions
    logic [BW-1:0]   w_bs;
    logic [QW-1:0]   w_cap;
    logic [BW:0]     w_trial;
    logic            w_qbit;
    logic            w_match;
    logic            w_k_end;
    logic            w_evict;
    logic            w_past;
    logic            w_seg_last;
    logic [BW-1:0]   w_blen;
    logic [PW-1:0]   w_diff;
    logic [1:0]      w_op;

    assign w_op = s_axis_tuser;

    // out-of-range block size and directory size are pulled into range
    always_comb begin
        if (r_bs_cfg == '0) begin
            w_bs = BW'(1);
        end else if (r_bs_cfg > brsf_pkg::BS_MAX) begin
            w_bs = brsf_pkg::BS_MAX;
        end else begin
            w_bs = r_bs_cfg;
        end
        if (r_ce_cfg == '0) begin
            w_cap = QW'(1);
        end else if (QW'(r_ce_cfg) > QW'(brsf_pkg::CACHE_DEPTH)) begin
            w_cap = QW'(brsf_pkg::CACHE_DEPTH);
        end else begin
            w_cap = QW'(r_ce_cfg);
        end
    end

    // restoring divider step
    assign w_trial = {r_rmd, r_dvd[PW-1]};
    assign w_qbit  = (w_trial >= {1'b0, w_bs});

    assign w_match    = (r_rdata == r_blk);
    assign w_k_end    = ((r_k + QW'(1)) == r_occ);
    assign w_evict    = (r_occ >= w_cap) && (r_occ != '0);
    assign w_past     = ({1'b0, r_base} + (PW+1)'(w_bs)) > {1'b0, r_sl};
    assign w_seg_last = (r_rem == CW'(r_len)) || (r_nseg == NW'(brsf_pkg::MAX_SEGMENTS - 1));
    assign w_blen     = w_bs - BW'(r_off);
    assign w_diff     = r_sl - r_pos;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brsf_pkg::ST_IDLE: begin
                if (w_in_go) begin
                    n_state = (w_op == brsf_pkg::OP_READ) ? brsf_pkg::ST_CLAMP
                                                          : brsf_pkg::ST_EMIT;
                end
            end
            brsf_pkg::ST_CLAMP:   n_state = brsf_pkg::ST_DIV;
            brsf_pkg::ST_DIV: begin
                if (r_dcnt == 6'(PW - 1)) n_state = brsf_pkg::ST_DIVDONE;
            end
            brsf_pkg::ST_DIVDONE: n_state = brsf_pkg::ST_LEN;
            brsf_pkg::ST_LEN: begin
                if (r_rem == '0) begin
                    n_state = brsf_pkg::ST_EMIT;
                end else if (r_occ == '0) begin
                    n_state = brsf_pkg::ST_MISS;
                end else begin
                    n_state = brsf_pkg::ST_SISSUE;
                end
            end
            brsf_pkg::ST_SISSUE:  n_state = brsf_pkg::ST_SCMP;
            brsf_pkg::ST_SCMP: begin
                if (w_match) begin
                    n_state = brsf_pkg::ST_UPD;
                end else if (w_k_end) begin
                    n_state = brsf_pkg::ST_MISS;
                end else begin
                    n_state = brsf_pkg::ST_SISSUE;
                end
            end
            brsf_pkg::ST_MISS: begin
                n_state = w_evict ? brsf_pkg::ST_EISSUE : brsf_pkg::ST_CHK;
            end
            brsf_pkg::ST_EISSUE:  n_state = brsf_pkg::ST_ERD;
            brsf_pkg::ST_ERD:     n_state = brsf_pkg::ST_CHK;
            brsf_pkg::ST_CHK: begin
                n_state = w_past ? brsf_pkg::ST_EMIT : brsf_pkg::ST_UPD;
            end
            brsf_pkg::ST_UPD:     n_state = brsf_pkg::ST_EMIT;
            brsf_pkg::ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = r_fin ? brsf_pkg::ST_IDLE : brsf_pkg::ST_NEXT;
                end
            end
            brsf_pkg::ST_NEXT:    n_state = brsf_pkg::ST_LEN;
            default:              n_state = brsf_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = (r_state == brsf_pkg::ST_IDLE);
        w_in_go       = s_axis_tvalid && s_axis_tready;
        w_emit_go     = (r_state == brsf_pkg::ST_EMIT) && (!r_ov || m_axis_tready);
        w_mem_we      = (r_state == brsf_pkg::ST_CHK) && !w_past;
        unique case (r_state)
            brsf_pkg::ST_SISSUE: w_raddr = r_head - SW'(1) - SW'(r_k);
            brsf_pkg::ST_EISSUE: w_raddr = r_head - SW'(r_occ);   // oldest valid entry
            default:             w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brsf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_cfg <= BW'(4096);
            r_ce_cfg <= EW'(16);
            r_sl     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                brsf_pkg::REG_BLK_BYTES:  r_bs_cfg <= i_cfg_data[BW-1:0];
                brsf_pkg::REG_CACHE_ENT:  r_ce_cfg <= i_cfg_data[EW-1:0];
                brsf_pkg::REG_STREAM_LEN: r_sl     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // directory tag store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ring[r_head] <= r_blk;
        end
        r_rdata <= r_ring[w_raddr];
    end

    // control state: position, directory pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_head <= '0;
            r_occ  <= '0;
        end else begin
            if (w_in_go) begin
                case (w_op)
                    brsf_pkg::OP_SEEK:  r_cur <= s_axis_tdata[47:0];
                    brsf_pkg::OP_FLUSH: begin
                        r_head <= '0;
                        r_occ  <= '0;
                    end
                    default: ;
                endcase
            end
            if (r_state == brsf_pkg::ST_ERD) begin
                r_occ <= r_occ - QW'(1);
            end
            if (w_mem_we) begin
                r_head <= r_head + SW'(1);
                if (r_occ < QW'(brsf_pkg::CACHE_DEPTH)) r_occ <= r_occ + QW'(1);
            end
            if ((r_state == brsf_pkg::ST_UPD) && w_seg_last) begin
                r_cur <= r_pos + PW'(r_len);
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            brsf_pkg::ST_IDLE: begin
                if (w_in_go) begin
                    r_pos   <= r_cur;
                    r_count <= s_axis_tdata[79:48];
                    r_blk   <= '0;
                    r_off   <= '0;
                    r_len   <= '0;
                    r_dst   <= '0;
                    r_hit   <= 1'b0;
                    r_slot  <= '0;
                    r_ev    <= 1'b0;
                    r_evb   <= '0;
                    r_err   <= 1'b0;
                    r_fin   <= 1'b1;
                    r_nseg  <= '0;
                    r_npos  <= (w_op == brsf_pkg::OP_SEEK) ? s_axis_tdata[47:0] : r_cur;
                end
            end
            brsf_pkg::ST_CLAMP: begin
                if (r_pos >= r_sl) begin
                    r_rem <= '0;
                end else if (w_diff > PW'(r_count)) begin
                    r_rem <= r_count;
                end else begin
                    r_rem <= w_diff[CW-1:0];
                end
                r_dvd  <= r_pos;
                r_rmd  <= '0;
                r_dcnt <= '0;
            end
            brsf_pkg::ST_DIV: begin
                r_rmd  <= w_qbit ? BW'(w_trial - {1'b0, w_bs}) : w_trial[BW-1:0];
                r_dvd  <= {r_dvd[PW-2:0], w_qbit};
                r_dcnt <= r_dcnt + 6'd1;
            end
            brsf_pkg::ST_DIVDONE: begin
                r_blk  <= r_dvd;
                r_off  <= r_rmd[OW-1:0];
                r_base <= r_pos - PW'(r_rmd);
            end
            brsf_pkg::ST_LEN: begin
                r_hit  <= 1'b0;
                r_slot <= '0;
                r_ev   <= 1'b0;
                r_evb  <= '0;
                r_err  <= 1'b0;
                r_k    <= '0;
                if (r_rem == '0) begin
                    // empty read: position only
                    r_len  <= '0;
                    r_npos <= r_pos;
                    r_fin  <= 1'b1;
                end else if (CW'(w_blen) > r_rem) begin
                    r_len <= r_rem[BW-1:0];
                end else begin
                    r_len <= w_blen;
                end
            end
            brsf_pkg::ST_SISSUE: r_probe <= w_raddr;
            brsf_pkg::ST_SCMP: begin
                if (w_match) begin
                    r_hit  <= 1'b1;
                    r_slot <= r_probe;
                end
                r_k <= r_k + QW'(1);
            end
            brsf_pkg::ST_ERD: begin
                r_ev  <= 1'b1;
                r_evb <= r_rdata;
            end
            brsf_pkg::ST_CHK: begin
                if (w_past) begin
                    // block runs past the stream end: end the run, position kept
                    r_err  <= 1'b1;
                    r_npos <= r_cur;
                    r_fin  <= 1'b1;
                end else begin
                    r_slot <= r_head;
                end
            end
            brsf_pkg::ST_UPD: begin
                r_npos <= r_pos + PW'(r_len);
                r_fin  <= w_seg_last;
            end
            brsf_pkg::ST_NEXT: begin
                r_pos  <= r_pos + PW'(r_len);
                r_rem  <= r_rem - CW'(r_len);
                r_dst  <= r_dst + CW'(r_len);
                r_nseg <= r_nseg + NW'(1);
                r_blk  <= r_blk + PW'(1);
                r_off  <= '0;
                r_base <= r_base + PW'(w_bs);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit_go) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_odata <= {r_npos, r_err, r_evb, r_ev, r_slot, r_hit, r_dst, r_len, r_off, r_blk};
            r_olast <= r_fin;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

`include "assert_macros.svh"

    // a taken request always leaves idle
    `CHK_NEXT(a_busy_after_accept, w_in_go, r_state != brsf_pkg::ST_IDLE)
    // a tag compare that matches marks the segment as hit
    `CHK_NEXT(a_match_sets_hit, (r_state == brsf_pkg::ST_SCMP) && w_match, r_hit)
    // an insert leaves the directory non-empty
    `CHK_NEXT(a_insert_occupies, w_mem_we, r_occ != '0)
    // the probe count never passes the occupancy
    `CHK_SAME(a_probe_bound, r_state == brsf_pkg::ST_SISSUE, r_k < r_occ)

endmodule
